FILE: rtl/core/cbs_pkg.sv
// Shared types and constants of the cubic Bezier sampler.
// Used by the controller, the datapath, the coordinate lanes and the top level.
`default_nettype none
package cbs_pkg;

    localparam int COORD_W       = 16;   // signed Q8.8 coordinate
    localparam int IDX_W         = 6;    // sample index and segment count
    localparam int CNT_W         = 4;    // step counter of the sequencer
    localparam int SQ_W          = 2 * IDX_W;
    localparam int CUBE_W        = 18;   // holds 62^3
    localparam int PROD_W        = CUBE_W + 1 + COORD_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int DSH_W         = CUBE_W + COORD_W;
    localparam int NUM_W         = ACC_W;
    localparam int DIV_STEPS     = COORD_W;
    localparam int N_POINTS      = 4;
    localparam int N_AXES        = 3;
    localparam int IN_W          = N_POINTS * N_AXES * COORD_W;
    localparam int OUT_W         = N_AXES * COORD_W + IDX_W;
    localparam int OUT_BUS_W     = ((OUT_W + 7) / 8) * 8;
    localparam int RESULT_BUDGET = 63;

    localparam logic [IDX_W-1:0] MAX_SEGMENTS = IDX_W'(62);
    localparam logic [IDX_W-1:0] SUBDIV_RESET = IDX_W'(62);
    localparam logic [IDX_W-1:0] DUP_LIMIT    = IDX_W'(RESULT_BUDGET - 3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_W1,
        ST_W2,
        ST_MUL,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_CUBE,
        OP_W1,
        OP_W2,
        OP_MUL,
        OP_ACC,
        OP_PREP,
        OP_DIV,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       k;      // control point row for a multiply step
        logic             first;  // first multiply step of a coordinate
        logic [IDX_W-1:0] n;      // segment count of the run
        logic [IDX_W-1:0] i;      // sample index
        logic             last;   // final result of the run
    } t_cmd;

    typedef struct packed {
        logic out_free;   // the output register can take a result this cycle
        logic in_ready;   // a curve beat is offered while the controller is ready for it
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/core/cubic_bezier_sampler.sv
// Top level of the cubic Bezier sampler: stream ports, controller and datapath.
// Depends on cbs_pkg, cbs_ctrl and cbs_dp.
//
//   Channel     Direction  Beat carries
//   s_axis      in         one curve: four control points p0..p3, x y z each
//   m_axis      out        one curve sample with its index; tlast on the final one
//   cfg         in         the subdivision register (segment count n)
//
// A curve is taken in its load step, then the squared and cubed segment count are
// formed. Each sample runs the shared per-sample sequence: two Bernstein weight
// steps, four multiply steps through the per-axis lanes, one accumulate, one set-up
// and sixteen steps of the bit-serial rounding divider, then the output step, which
// emits the end sample twice where it is repeated.
// Reset is synchronous and active low; the subdivision register returns to 62.
// A stalled output holds the current result; the sequencer waits only when a
// new result is ready and the previous one has not yet left.
`default_nettype none
module cubic_bezier_sampler
    import cbs_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Control points, lowest bits first: p0_x p0_y p0_z p1_x p1_y p1_z
    // p2_x p2_y p2_z p3_x p3_y p3_z, each signed Q8.8.
    input  wire [IN_W-1:0]       i_s_axis_tdata,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Sample, lowest bits first: point_x point_y point_z sample_index, zero pad.
    output logic [OUT_BUS_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    input  wire [IDX_W-1:0]      i_cfg_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready
);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic             w_in_ready;
    logic [OUT_W-1:0] w_out_data;

    // The datapath only sees a beat as valid while the controller is ready for it.
    cbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_in_ready  (w_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_axis_tdata),
        .i_in_valid  (i_s_axis_tvalid && w_in_ready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (w_out_data),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tdata  = {{(OUT_BUS_W - OUT_W){1'b0}}, w_out_data};

endmodule
`default_nettype wire

FILE: rtl/core/cbs_lane.sv
// One coordinate lane: weighted accumulation and a bit-serial rounding divider.
// Depends on cbs_pkg.
`default_nettype none
module cbs_lane
    import cbs_pkg::*;
(
    input  wire                      i_clk,
    input  t_op                      i_op,
    input  wire                      i_first,
    input  wire [CUBE_W-1:0]         i_w,
    input  wire signed [COORD_W-1:0] i_p,
    input  wire [CUBE_W-1:0]         i_d,
    output logic [COORD_W-1:0]       o_q
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [NUM_W-1:0]         r_rem;
    logic [DSH_W-1:0]         r_dsh;
    logic [COORD_W-1:0]       r_q;
    logic [NUM_W:0]           n_num;
    logic                     w_ge;

    // Offset numerator: 2*acc + d + 65536*d, which keeps the quotient positive.
    assign n_num = {r_acc, 1'b0} + {{(NUM_W + 1 - CUBE_W){1'b0}}, i_d}
                 + {{(NUM_W + 1 - DSH_W){1'b0}}, i_d, {COORD_W{1'b0}}};
    assign w_ge  = r_rem >= {{(NUM_W - DSH_W){1'b0}}, r_dsh};

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_MUL: begin
                r_prod <= $signed({1'b0, i_w}) * i_p;
                if (i_first) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            OP_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_PREP: begin
                r_rem <= n_num[NUM_W-1:0];
                r_dsh <= {i_d, {COORD_W{1'b0}}};
            end
            OP_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - {{(NUM_W - DSH_W){1'b0}}, r_dsh};
                end
                r_q   <= {r_q[COORD_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
            end
            default: begin
            end
        endcase
    end

    // Remove the offset of half the quotient range.
    assign o_q = {~r_q[COORD_W-1], r_q[COORD_W-2:0]};

endmodule
`default_nettype wire

FILE: rtl/core/cbs_dp.sv
// Datapath: control point store, Bernstein weights, three lanes, output register.
// Depends on cbs_pkg and cbs_lane.
`default_nettype none
module cbs_dp
    import cbs_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  wire [IN_W-1:0]       i_in_data,
    input  wire                  i_in_valid,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [OUT_W-1:0]     o_out_data,
    output logic                 o_out_last
);

    logic signed [COORD_W-1:0] r_cp [N_POINTS][N_AXES];
    logic [SQ_W-1:0]           r_nn;
    logic [CUBE_W-1:0]         r_d;
    logic [SQ_W-1:0]           r_uu;
    logic [SQ_W-1:0]           r_vv;
    logic [CUBE_W-1:0]         r_w  [N_POINTS];
    logic [COORD_W-1:0]        w_q  [N_AXES];
    logic [IDX_W-1:0]          w_u;
    logic [CUBE_W-1:0]         w_t1;
    logic [CUBE_W-1:0]         w_t2;
    logic [CUBE_W+1:0]         w_w1;
    logic [CUBE_W+1:0]         w_w2;
    logic                      r_valid;
    logic [OUT_W-1:0]          r_data;
    logic                      r_last;

    assign w_u  = i_cmd.n - i_cmd.i;
    assign w_t1 = r_uu * i_cmd.i;
    assign w_t2 = r_vv * w_u;
    assign w_w1 = {2'b00, w_t1} + {1'b0, w_t1, 1'b0};
    assign w_w2 = {2'b00, w_t2} + {1'b0, w_t2, 1'b0};

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < N_POINTS; k++) begin
                    for (int c = 0; c < N_AXES; c++) begin
                        r_cp[k][c] <= i_in_data[(k*N_AXES + c)*COORD_W +: COORD_W];
                    end
                end
            end
            OP_SQ: begin
                r_nn <= i_cmd.n * i_cmd.n;
            end
            OP_CUBE: begin
                r_d <= r_nn * i_cmd.n;
            end
            OP_W1: begin
                r_uu <= w_u * w_u;
                r_vv <= i_cmd.i * i_cmd.i;
            end
            OP_W2: begin
                r_w[0] <= r_uu * w_u;
                r_w[1] <= w_w1[CUBE_W-1:0];
                r_w[2] <= w_w2[CUBE_W-1:0];
                r_w[3] <= r_vv * i_cmd.i;
            end
            default: begin
            end
        endcase
    end

    for (genvar c = 0; c < N_AXES; c++) begin : g_lane
        cbs_lane u_lane (
            .i_clk   (i_clk),
            .i_op    (i_cmd.op),
            .i_first (i_cmd.first),
            .i_w     (r_w[i_cmd.k]),
            .i_p     (r_cp[i_cmd.k][c]),
            .i_d     (r_d),
            .o_q     (w_q[c])
        );
    end

    // Output register: a held result leaves while the next one is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_data <= {i_cmd.i, w_q[2], w_q[1], w_q[0]};
            r_last <= i_cmd.last;
        end
    end

    assign o_stat.out_free = !r_valid || i_out_ready;
    assign o_stat.in_ready = i_in_valid;
    assign o_out_valid     = r_valid;
    assign o_out_data      = r_data;
    assign o_out_last      = r_last;

endmodule
`default_nettype wire

FILE: rtl/core/cbs_ctrl.sv
// Controller: subdivision register, sample counter and the step sequencer.
// Depends on cbs_pkg.
`default_nettype none
module cbs_ctrl
    import cbs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_valid,
    input  wire [IDX_W-1:0]  i_cfg_data,
    output logic             o_cfg_ready,
    output logic             o_in_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_subdiv;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_dup, n_dup;
    logic [IDX_W-1:0] w_nclamp;
    logic             w_end;
    logic             w_dbl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_subdiv <= SUBDIV_RESET;
            r_n      <= '0;
            r_i      <= '0;
            r_cnt    <= '0;
            r_dup    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_dup   <= n_dup;
            if (i_cfg_valid) begin
                r_subdiv <= i_cfg_data;
            end
        end
    end

    assign w_nclamp = (r_subdiv == '0) ? IDX_W'(1) :
                      (r_subdiv > MAX_SEGMENTS) ? MAX_SEGMENTS : r_subdiv;
    assign w_end    = (r_i == '0) || (r_i == r_n);
    assign w_dbl    = r_n <= DUP_LIMIT;

    // Neither channel takes a beat while reset is held.
    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_cnt       = r_cnt;
        n_dup       = r_dup;
        o_cmd.op    = OP_NONE;
        o_cmd.k     = r_cnt[1:0];
        o_cmd.first = r_cnt == '0;
        o_cmd.n     = r_n;
        o_cmd.i     = r_i;
        o_cmd.last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_stat.in_ready) begin
                    o_cmd.op = OP_LOAD;
                    n_n      = w_nclamp;
                    n_i      = '0;
                    n_cnt    = '0;
                    n_dup    = 1'b0;
                    n_state  = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = ST_CUBE;
            end
            ST_CUBE: begin
                o_cmd.op = OP_CUBE;
                n_state  = ST_W1;
            end
            ST_W1: begin
                o_cmd.op = OP_W1;
                n_state  = ST_W2;
            end
            ST_W2: begin
                o_cmd.op = OP_W2;
                n_cnt    = '0;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                if (r_cnt == CNT_W'(N_POINTS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (w_dbl && w_end && !r_dup) begin
                        n_dup = 1'b1;
                    end else begin
                        o_cmd.last = r_i == r_n;
                        n_dup      = 1'b0;
                        if (r_i == r_n) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i     = r_i + IDX_W'(1);
                            n_state = ST_W1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
